@@ src/assert_macros.svh @@
// Assertion macros shared by the key event block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define HKRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hkrd assertion failed");

// Checks that a condition implies another in the same cycle.
`define HKRD_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hkrd assertion failed");

`else

`define HKRD_ASSERT(label, clk, rst, prop)
`define HKRD_ASSERT_IMPLIES(label, clk, rst, pre, post)

`endif

`endif

@@ src/hkrd_pkg.sv @@
// Types and constants for the HID boot keyboard report differ.
// Used by every module of the block; depends on nothing.
package hkrd_pkg;

   // Report layout.
   localparam int KEY_SLOTS = 6;
   localparam int MOD_BITS  = 8;
   localparam int CODE_W    = 8;

   // Event limits and special codes.
   localparam int MAX_EVENTS = 20;
   localparam logic [CODE_W-1:0] MODIFIER_BASE = 8'hE0;
   localparam logic [CODE_W-1:0] ROLLOVER_MAX  = 8'h03;

   // One candidate event per modifier bit, then a press and a release per key slot.
   localparam int EVENT_SLOTS = MOD_BITS + 2 * KEY_SLOTS;
   localparam int EVENT_IDX_W = $clog2(EVENT_SLOTS);
   localparam int SLOT_IDX_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int MOD_IDX_W   = $clog2(MOD_BITS);
   localparam int COUNT_W     = $clog2(MAX_EVENTS);

   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_array_type;
   typedef logic [EVENT_SLOTS-1:0]           event_mask_type;

   // A classified report waiting to be serialized into events.
   typedef struct packed {
      event_mask_type         mask;
      logic [MOD_BITS-1:0]    mods;
      key_array_type          new_keys;
      key_array_type          old_keys;
   } event_entry_type;

   // Queue occupancy seen by the top level and the back part.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ src/hkrd_req_if.sv @@
// Report channel: valid/ready handshake carrying one boot keyboard report.
// Standalone interface; no dependencies.
interface hkrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifier_bits;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;

   modport source (
      output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5,
      input  ready
   );

   modport sink (
      input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5,
      output ready
   );
endinterface

@@ src/hkrd_rsp_if.sv @@
// Event channel: valid/ready handshake carrying one key press or release.
// Standalone interface; no dependencies.
interface hkrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] usage_code;
   logic       released;
   logic       last_event;

   modport source (
      output valid, usage_code, released, last_event,
      input  ready
   );

   modport sink (
      input  valid, usage_code, released, last_event,
      output ready
   );
endinterface

@@ src/hkrd_front.sv @@
// Front part: keeps the previous report and classifies each new one into an event mask.
// Depends on hkrd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkrd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [hkrd_pkg::MOD_BITS-1:0] mods,
   input  hkrd_pkg::key_array_type    keys,
   output logic                       push,
   output hkrd_pkg::event_entry_type  entry
);

   logic [hkrd_pkg::MOD_BITS-1:0] mods_ff, mods_in;
   hkrd_pkg::key_array_type       keys_ff, keys_in;
   logic                          rollover;
   hkrd_pkg::event_mask_type      mask;

   // A first slot holding an error code in 1..3 marks a rollover report.
   assign rollover = (keys[0] != '0) && (keys[0] <= hkrd_pkg::ROLLOVER_MAX);

   // Modifier changes, then per slot a press of a new key and a release of an old key.
   always_comb begin
      logic new_seen;
      logic old_seen;
      mask = '0;
      mask[hkrd_pkg::MOD_BITS-1:0] = mods ^ mods_ff;
      for (int s = 0; s < hkrd_pkg::KEY_SLOTS; s++) begin
         new_seen = 1'b0;
         old_seen = 1'b0;
         for (int k = 0; k < hkrd_pkg::KEY_SLOTS; k++) begin
            if (keys_ff[k] == keys[s]) begin
               new_seen = 1'b1;
            end
            if (keys[k] == keys_ff[s]) begin
               old_seen = 1'b1;
            end
         end
         mask[hkrd_pkg::MOD_BITS + 2 * s] =
            !rollover && (keys[s] > hkrd_pkg::ROLLOVER_MAX) && !new_seen;
         mask[hkrd_pkg::MOD_BITS + 2 * s + 1] =
            !rollover && (keys_ff[s] > hkrd_pkg::ROLLOVER_MAX) && !old_seen;
      end
   end

   // An unchanged report yields an empty mask and is not queued.
   assign push           = accept && (mask != '0);
   assign entry.mask     = mask;
   assign entry.mods     = mods;
   assign entry.new_keys = keys;
   assign entry.old_keys = keys_ff;

   // Stored report: modifiers always follow, keys only outside rollover.
   always_comb begin
      mods_in = mods_ff;
      keys_in = keys_ff;
      if (accept) begin
         mods_in = mods;
         if (!rollover) begin
            keys_in = keys;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= '0;
         keys_ff <= '0;
      end else begin
         mods_ff <= mods_in;
         keys_ff <= keys_in;
      end
   end

   // A rollover report must leave the stored keys alone.
   `HKRD_ASSERT(rollover_keeps_keys_a, clock, reset, (accept && rollover) |=> $stable(keys_ff))
   // Only a report that carries at least one event is queued.
   `HKRD_ASSERT_IMPLIES(push_has_events_a, clock, reset, push, (entry.mask != '0))

endmodule

@@ src/hkrd_queue.sv @@
// Short queue of classified reports between the front and back parts.
// Depends on hkrd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkrd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  hkrd_pkg::event_entry_type    push_entry,
   input  logic                         pop,
   output hkrd_pkg::event_entry_type    head,
   output hkrd_pkg::queue_status_type   status
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   hkrd_pkg::event_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   assign status.full  = (count_ff == COUNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update; pointers wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Occupancy never passes the depth, and a full queue is not written unless it is popped at the same time.
   `HKRD_ASSERT(queue_bound_a, clock, reset, count_ff <= COUNT_W'(DEPTH))
   `HKRD_ASSERT_IMPLIES(no_push_when_full_a, clock, reset, status.full && !pop, !push)

endmodule

@@ src/hkrd_back.sv @@
// Back part: serializes the queued event masks into single press/release transactions.
// Depends on hkrd_pkg, hkrd_rsp_if and assert_macros.svh.
`include "assert_macros.svh"

module hkrd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  hkrd_pkg::event_entry_type   head,
   input  hkrd_pkg::queue_status_type  status,
   output logic                        pop,
   hkrd_rsp_if.source                  rsp_bus
);

   logic                                  work_valid_ff, work_valid_in;
   hkrd_pkg::event_entry_type             work_ff, work_in;
   logic [hkrd_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [hkrd_pkg::CODE_W-1:0]           usage_ff;
   logic                                  released_ff;
   logic                                  last_ff;

   hkrd_pkg::event_mask_type              lowest;
   hkrd_pkg::event_mask_type              remaining;
   logic [hkrd_pkg::EVENT_IDX_W-1:0]      idx;
   logic [hkrd_pkg::EVENT_IDX_W-1:0]      key_pos;
   logic [hkrd_pkg::SLOT_IDX_W-1:0]       slot;
   logic [hkrd_pkg::CODE_W-1:0]           event_code;
   logic                                  event_released;
   logic                                  last;
   logic                                  emit;
   logic                                  load;

   // Lowest pending event of the current report.
   assign lowest    = work_ff.mask & (~work_ff.mask + hkrd_pkg::EVENT_SLOTS'(1));
   assign remaining = work_ff.mask & ~lowest;

   always_comb begin
      idx = '0;
      for (int i = 0; i < hkrd_pkg::EVENT_SLOTS; i++) begin
         if (lowest[i]) begin
            idx = idx | hkrd_pkg::EVENT_IDX_W'(i);
         end
      end
   end

   // Decode the event position into a usage code and a direction.
   assign key_pos = idx - hkrd_pkg::EVENT_IDX_W'(hkrd_pkg::MOD_BITS);
   assign slot    = key_pos[hkrd_pkg::SLOT_IDX_W:1];

   always_comb begin
      if (idx < hkrd_pkg::EVENT_IDX_W'(hkrd_pkg::MOD_BITS)) begin
         event_code     = hkrd_pkg::MODIFIER_BASE |
                          hkrd_pkg::CODE_W'(idx[hkrd_pkg::MOD_IDX_W-1:0]);
         event_released = !work_ff.mods[idx[hkrd_pkg::MOD_IDX_W-1:0]];
      end else if (key_pos[0]) begin
         event_code     = work_ff.old_keys[slot];
         event_released = 1'b1;
      end else begin
         event_code     = work_ff.new_keys[slot];
         event_released = 1'b0;
      end
   end

   // The run ends when nothing is pending or the event limit is reached.
   assign last = (remaining == '0) ||
                 (count_ff == hkrd_pkg::COUNT_W'(hkrd_pkg::MAX_EVENTS - 1));
   assign emit = work_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign load = !status.empty && (!work_valid_ff || (emit && last));
   assign pop  = load;

   // Working report and event counter.
   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      count_in      = count_ff;
      if (emit) begin
         work_in.mask = remaining;
         if (last) begin
            work_valid_in = 1'b0;
            count_in      = '0;
         end else begin
            count_in = count_ff + hkrd_pkg::COUNT_W'(1);
         end
      end
      if (load) begin
         work_valid_in = 1'b1;
         work_in       = head;
      end
   end

   // Output register: a new event enters when the slot is free or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         usage_ff    <= event_code;
         released_ff <= event_released;
         last_ff     <= last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.usage_code = usage_ff;
   assign rsp_bus.released   = released_ff;
   assign rsp_bus.last_event = last_ff;

   // A live working report always has an event pending, and the count stays in range.
   `HKRD_ASSERT_IMPLIES(work_has_event_a, clock, reset, work_valid_ff, (work_ff.mask != '0))
   `HKRD_ASSERT(count_bound_a, clock, reset, count_ff < hkrd_pkg::COUNT_W'(hkrd_pkg::MAX_EVENTS))
   // Finishing a run with nothing queued leaves the back part empty.
   `HKRD_ASSERT(run_end_a, clock, reset, (emit && last && !load) |=> !work_valid_ff)

endmodule

@@ src/hid_keyboard_report_differ_top.sv @@
// Top level of the HID boot keyboard report differ.
// Depends on hkrd_pkg, hkrd_req_if, hkrd_rsp_if, hkrd_front, hkrd_queue and hkrd_back.

// Each accepted report is compared combinationally with the previously stored report, and
// the stored state is updated at once; a report that produces events is placed in a
// queue of QUEUE_DEPTH entries. The serializer behind the queue sends one event per
// cycle while the receiver keeps ready high, through a registered output, modifier
// changes first in bit order, then key presses and releases slot by slot, with
// last_event set on the final one and at most 20 events per report. A queued report
// carries 1 to 20 events (a report that causes no events is not queued), and reports
// are accepted back to back, one per cycle, while the queue has room.
module hid_keyboard_report_differ_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   hkrd_req_if.sink      req_bus,
   hkrd_rsp_if.source    rsp_bus
);

   logic                        accept;
   logic                        push;
   logic                        pop;
   hkrd_pkg::key_array_type     keys;
   hkrd_pkg::event_entry_type   push_entry;
   hkrd_pkg::event_entry_type   head;
   hkrd_pkg::queue_status_type  status;

   // A report transaction is taken whenever the queue can hold its events.
   assign req_bus.ready = !status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   assign keys[0] = req_bus.key_slot_0;
   assign keys[1] = req_bus.key_slot_1;
   assign keys[2] = req_bus.key_slot_2;
   assign keys[3] = req_bus.key_slot_3;
   assign keys[4] = req_bus.key_slot_4;
   assign keys[5] = req_bus.key_slot_5;

   hkrd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .mods   (req_bus.modifier_bits),
      .keys   (keys),
      .push   (push),
      .entry  (push_entry)
   );

   hkrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   hkrd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .status  (status),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for hid_keyboard_report_differ_top: sends boot keyboard reports
// and checks the serialized key events. Depends on hkrd_pkg, hkrd_req_if, hkrd_rsp_if and
// the top-level module of the block.
module tb;

   // One boot keyboard report as sent on the report channel.
   typedef struct packed {
      logic [hkrd_pkg::MOD_BITS-1:0] mods;
      hkrd_pkg::key_array_type       keys;
   } kbd_report_type;

   // One key event as produced on the event channel.
   typedef struct packed {
      logic [hkrd_pkg::CODE_W-1:0] usage;
      logic                        released;
      logic                        is_last;
   } key_event_type;

   // Receiver stall patterns.
   typedef enum int {
      RX_STREAM,
      RX_RANDOM_STALLS,
      RX_ALTERNATE,
      RX_COIN_FLIP
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hkrd_req_if req_bus ();
   hkrd_rsp_if rsp_bus ();

   hid_keyboard_report_differ_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Predictor state: the last report the block has stored.
   logic [hkrd_pkg::MOD_BITS-1:0] stored_mods = '0;
   hkrd_pkg::key_array_type       stored_keys = '0;

   key_event_type expected_key_events[$];
   key_event_type report_events[$];

   int error_count     = 0;
   int events_checked  = 0;
   int reports_sent    = 0;
   int reports_silent  = 0;
   int reports_rollover = 0;
   int largest_run     = 0;
   int burst_left      = 0;

   // Returns whether any slot of a key array holds the given code.
   function automatic bit keys_hold(input hkrd_pkg::key_array_type slots,
                                    input logic [hkrd_pkg::CODE_W-1:0] code);
      for (int k = 0; k < hkrd_pkg::KEY_SLOTS; k++)
         if (slots[k] == code) return 1'b1;
      return 1'b0;
   endfunction

   // Adds one event to the current report's run, dropping any beyond the limit.
   function automatic void stage_event(input logic [hkrd_pkg::CODE_W-1:0] usage,
                                       input logic up);
      if (report_events.size() < hkrd_pkg::MAX_EVENTS)
         report_events.push_back(key_event_type'{usage, up, 1'b0});
   endfunction

   // Works out the events of one accepted report and updates the stored report.
   function automatic void predict_key_events(input kbd_report_type r);
      logic [hkrd_pkg::MOD_BITS-1:0] changed;
      logic [hkrd_pkg::CODE_W-1:0]   new_code;
      logic [hkrd_pkg::CODE_W-1:0]   old_code;
      report_events.delete();
      if (r.mods == stored_mods && r.keys == stored_keys) begin
         reports_silent++;
         return;
      end
      // Modifier changes come first, in bit order.
      changed = r.mods ^ stored_mods;
      for (int b = 0; b < hkrd_pkg::MOD_BITS; b++)
         if (changed[b])
            stage_event(hkrd_pkg::MODIFIER_BASE + hkrd_pkg::CODE_W'(b), !r.mods[b]);
      stored_mods = r.mods;
      // Key slots are compared only when the report is not a rollover report.
      if (r.keys[0] == '0 || r.keys[0] > hkrd_pkg::ROLLOVER_MAX) begin
         for (int s = 0; s < hkrd_pkg::KEY_SLOTS; s++) begin
            new_code = r.keys[s];
            old_code = stored_keys[s];
            if (new_code > hkrd_pkg::ROLLOVER_MAX && !keys_hold(stored_keys, new_code))
               stage_event(new_code, 1'b0);
            if (old_code > hkrd_pkg::ROLLOVER_MAX && !keys_hold(r.keys, old_code))
               stage_event(old_code, 1'b1);
         end
         stored_keys = r.keys;
      end else begin
         reports_rollover++;
      end
      if (report_events.size() == 0) reports_silent++;
      if (report_events.size() > largest_run) largest_run = report_events.size();
      foreach (report_events[i]) begin
         expected_key_events.push_back(key_event_type'{report_events[i].usage,
            report_events[i].released, 1'(i == report_events.size() - 1)});
      end
   endfunction

   function automatic kbd_report_type make_report(input logic [7:0] mods,
      input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2,
      input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
      kbd_report_type r;
      r.mods    = mods;
      r.keys[0] = k0;
      r.keys[1] = k1;
      r.keys[2] = k2;
      r.keys[3] = k3;
      r.keys[4] = k4;
      r.keys[5] = k5;
      return r;
   endfunction

   // Sends one report, idling between bursts, and predicts its events on acceptance.
   task automatic send_report(input kbd_report_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.modifier_bits <= r.mods;
      req_bus.key_slot_0    <= r.keys[0];
      req_bus.key_slot_1    <= r.keys[1];
      req_bus.key_slot_2    <= r.keys[2];
      req_bus.key_slot_3    <= r.keys[3];
      req_bus.key_slot_4    <= r.keys[4];
      req_bus.key_slot_5    <= r.keys[5];
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_key_events(r);
      reports_sent++;
   endtask

   // Holds the sender off until every expected event has arrived.
   task automatic drain_events();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_key_events.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic test_idle_report();
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_events();
   endtask

   task automatic test_modifiers();
      send_report(make_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_events();
   endtask

   task automatic test_key_presses();
      send_report(make_report(8'hA5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_report(make_report(8'hA5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      drain_events();
   endtask

   // Rollover reports move modifiers but leave the stored keys alone.
   task automatic test_rollover();
      send_report(make_report(8'h5A, 8'h01, 8'h02, 8'h03, 8'h00, 8'hFF, 8'h10));
      send_report(make_report(8'h5A, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02));
      send_report(make_report(8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00));
      drain_events();
   endtask

   // Changes confined to codes 0 to 3 give no events.
   task automatic test_silent_change();
      send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h03));
      send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h01));
      drain_events();
   endtask

   // A code held in two slots is pressed and released twice.
   task automatic test_duplicates();
      send_report(make_report(8'h00, 8'h2A, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_events();
   endtask

   // Every modifier flips while all six keys are replaced: the longest run.
   task automatic test_event_limit();
      send_report(make_report(8'hFF, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
      send_report(make_report(8'h00, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25));
      drain_events();
   endtask

   task automatic test_field_extremes();
      send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_report(make_report(8'h80, 8'h04, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_events();
   endtask

   // Mostly typing sequences built on the previous report, with some noise.
   task automatic test_random_typing(input int count);
      kbd_report_type          r;
      hkrd_pkg::key_array_type held_keys;
      logic [7:0]              held_mods;
      int                      choice;
      int                      slot;
      int                      other;
      bit                      rollover;
      held_keys = stored_keys;
      held_mods = stored_mods;
      repeat (count) begin
         r.mods   = held_mods;
         r.keys   = held_keys;
         rollover = 1'b0;
         choice   = $urandom_range(0, 99);
         if (choice < 30) begin
            // Press a key in the first empty slot, or over a random one.
            slot = $urandom_range(0, hkrd_pkg::KEY_SLOTS - 1);
            for (int s = hkrd_pkg::KEY_SLOTS - 1; s >= 0; s--)
               if (r.keys[s] == '0) slot = s;
            r.keys[slot] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(4, 8'h31))
                                                       : 8'($urandom_range(4, 255));
         end else if (choice < 52) begin
            r.keys[$urandom_range(0, hkrd_pkg::KEY_SLOTS - 1)] = '0;
         end else if (choice < 65) begin
            if ($urandom_range(0, 3) == 0) r.mods = 8'($urandom);
            else r.mods[$urandom_range(0, hkrd_pkg::MOD_BITS - 1)] ^= 1'b1;
         end else if (choice < 70) begin
            // Repeat the previous report unchanged.
         end else if (choice < 76) begin
            rollover  = 1'b1;
            r.keys[0] = 8'($urandom_range(1, 3));
            for (int s = 1; s < hkrd_pkg::KEY_SLOTS; s++)
               r.keys[s] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom);
            if ($urandom_range(0, 1) == 0) r.mods = 8'($urandom);
         end else if (choice < 81) begin
            r.keys[$urandom_range(1, hkrd_pkg::KEY_SLOTS - 1)] = 8'($urandom_range(0, 3));
         end else if (choice < 87) begin
            slot  = $urandom_range(0, hkrd_pkg::KEY_SLOTS - 1);
            other = $urandom_range(0, hkrd_pkg::KEY_SLOTS - 1);
            if (r.keys[slot] <= hkrd_pkg::ROLLOVER_MAX)
               r.keys[slot] = 8'($urandom_range(4, 255));
            r.keys[other] = r.keys[slot];
         end else begin
            r.mods = 8'($urandom);
            for (int s = 0; s < hkrd_pkg::KEY_SLOTS; s++) r.keys[s] = 8'($urandom);
         end
         send_report(r);
         held_mods = r.mods;
         if (!rollover) held_keys = r.keys;
         if (held_keys[0] inside {[8'h01 : hkrd_pkg::ROLLOVER_MAX]}) held_keys[0] = '0;
         if ($urandom_range(0, 79) == 0) drain_events();
      end
      drain_events();
   endtask

   // Receiver: switches between randomly chosen stall patterns.
   rx_pattern_type rx_pattern = RX_STREAM;
   int             rx_cycle   = 0;
   int             stall_left = 0;

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_pattern = rx_pattern_type'($urandom_range(0, 3));
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_STREAM: begin
               rsp_bus.ready <= 1'b1;
            end
            RX_RANDOM_STALLS: begin
               if ($urandom_range(0, 3) == 0) begin
                  stall_left = $urandom_range(0, 7);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
            RX_ALTERNATE: begin
               rsp_bus.ready <= rx_cycle[0];
            end
            default: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
         endcase
      end
   end

   // Compares each accepted event with the oldest expected one.
   always @(posedge clock) begin
      key_event_type got;
      key_event_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = key_event_type'{rsp_bus.usage_code, rsp_bus.released, rsp_bus.last_event};
         if (expected_key_events.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected event: usage %02h released %0b last %0b",
                        $realtime, got.usage, got.released, got.is_last);
         end else begin
            want = expected_key_events.pop_front();
            events_checked++;
            if (got.usage !== want.usage || got.released !== want.released ||
                got.is_last !== want.is_last) begin
               error_count++;
               if (error_count <= 10)
                  $display({"%0t: event mismatch: expected usage %02h released %0b last %0b,",
                            " got usage %02h released %0b last %0b"}, $realtime,
                           want.usage, want.released, want.is_last,
                           got.usage, got.released, got.is_last);
            end
         end
      end
   end

   // Main sequence: reset, directed tests, random typing, then the verdict.
   initial begin
      req_bus.valid         = 1'b0;
      req_bus.modifier_bits = '0;
      req_bus.key_slot_0    = '0;
      req_bus.key_slot_1    = '0;
      req_bus.key_slot_2    = '0;
      req_bus.key_slot_3    = '0;
      req_bus.key_slot_4    = '0;
      req_bus.key_slot_5    = '0;
      rsp_bus.ready         = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_report();
      test_modifiers();
      test_key_presses();
      test_rollover();
      test_silent_change();
      test_duplicates();
      test_event_limit();
      test_field_extremes();
      test_random_typing(420);

      // Let any stray event show up after the last expected one.
      repeat (50) @(posedge clock);
      $display("Covered %0d reports (%0d rollover, %0d without events) and %0d key events.",
               reports_sent, reports_rollover, reports_silent, events_checked);
      $display("Longest event run %0d; %0d failures.", largest_run, error_count);
      if (error_count == 0 && expected_key_events.size() == 0) begin
         $display("hid_keyboard_report_differ_top regression: pass");
      end else begin
         $display("hid_keyboard_report_differ_top regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("hid_keyboard_report_differ_top regression: fail");
      $finish;
   end

endmodule
